/* hw/rtl/ksq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ksq_pkg
// Shared types, operation codes and translation tables for the keyboard
// scan queue.
// ----------------------------------------------------------------------------
package ksq_pkg;

    // key code geometry
    localparam int KEY_W     = 7;
    localparam int KEY_COUNT = 128;
    localparam int ROM_SEARCH_LIMIT = 255;

    // operation codes
    localparam logic [2:0] OP_SCAN   = 3'd0;
    localparam logic [2:0] OP_POP    = 3'd1;
    localparam logic [2:0] OP_LAST   = 3'd2;
    localparam logic [2:0] OP_PSCAN  = 3'd3;
    localparam logic [2:0] OP_PASCII = 3'd4;
    localparam logic [2:0] OP_FLUSH  = 3'd5;

    // where the result of a request comes from
    typedef enum logic [1:0] {
        RES_ZERO  = 2'd0,
        RES_IMM   = 2'd1,
        RES_ASCII = 2'd2,
        RES_BIT   = 2'd3
    } res_kind_t;

    // ring control and status between top level and ring
    typedef struct packed {
        logic             push;
        logic             pop;
        logic             flush;
        logic [KEY_W-1:0] key;
    } ksq_ring_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } ksq_ring_stat_t;

    typedef logic [7:0] byte_rom_t [256];

    // scan code to ascii, unshifted half then shifted half
    localparam byte_rom_t ASCII_ROM = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h8B, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h89, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h8A, 8'h00,
        8'h8C, 8'h20, 8'h00, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91,
        8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h00, 8'h00, 8'h84,
        8'h82, 8'h85, 8'h00, 8'h80, 8'h00, 8'h81, 8'h00, 8'h86,
        8'h83, 8'h87, 8'h88, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h97,
        8'h98, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h8B, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h89, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h8A, 8'h00,
        8'h8C, 8'h20, 8'h00, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91,
        8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h00, 8'h00, 8'h84,
        8'h82, 8'h85, 8'h00, 8'h80, 8'h00, 8'h81, 8'h00, 8'h86,
        8'h83, 8'h87, 8'h88, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h97,
        8'h98, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // reverse table: bit 7 marks a match, bits 6:0 the key of the first match
    function automatic byte_rom_t build_rev_rom();
        byte_rom_t r;
        for (int i = 0; i < 256; i++)
        begin
            r[i] = 8'h00;
        end
        // walk downwards so the lowest matching entry wins
        for (int i = ROM_SEARCH_LIMIT - 1; i >= 0; i--)
        begin
            r[ASCII_ROM[i]] = {1'b1, i[6:0]};
        end
        return r;
    endfunction

    localparam byte_rom_t REV_ROM = build_rev_rom();

endpackage
`default_nettype wire

/* hw/rtl/ksq_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ksq_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ksq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* hw/rtl/ksq_ring.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ksq_ring
// Press ring: head and tail pointers around a RAM of key codes. A push into
// a full ring is dropped; a pop of an empty ring leaves the pointers alone.
// ----------------------------------------------------------------------------
module ksq_ring #(
    parameter int RING_DEPTH = 128
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ksq_pkg::ksq_ring_cmd_t cmd,
    output ksq_pkg::ksq_ring_stat_t     stat,
    output logic [ksq_pkg::KEY_W-1:0]   rd_key
);
    import ksq_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);

    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [PTR_W-1:0] tail_inc;
    logic [PTR_W-1:0] head_inc;
    logic             ring_we;

    // wrapping increments
    assign tail_inc = (tail_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign head_inc = (head_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    assign stat.empty = (head_reg == tail_reg);
    assign stat.full  = (tail_inc == head_reg);

    assign ring_we = cmd.push && !stat.full;

    // pointer update
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (cmd.flush)
        begin
            head_next = '0;
            tail_next = '0;
        end
        else
        begin
            if (ring_we)
            begin
                tail_next = tail_inc;
            end
            if (cmd.pop && !stat.empty)
            begin
                head_next = head_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // key storage, always read at the head
    ksq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (RING_DEPTH)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (tail_reg),
        .wdata (cmd.key),
        .raddr (head_reg),
        .rdata (rd_key)
    );

endmodule
`default_nettype wire

/* hw/rtl/keyboard_scan_queue_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// keyboard_scan_queue_core
// Set-1 scan code keyboard buffer: pressed map, press ring with ascii pop,
// last hit latch, pressed queries by scan code and by ascii code.
// ----------------------------------------------------------------------------
// done: registered from the execute state, high for one cycle
// requests: busy covers the execute state and the registered read of the
//   pressed map and ring memories; a new request is taken only in idle
// reset: pointers and last hit clear at once, then a pass over every
//   pressed map entry zeroes it with busy held high
// results cannot be stalled by the receiver
// ----------------------------------------------------------------------------
module keyboard_scan_queue_core #(
    parameter int RING_DEPTH = 128
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] operation,
    input  wire logic [7:0] data_byte,
    output logic            done,
    output logic      [7:0] read_value
);
    import ksq_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [KEY_W-1:0]  clr_cnt_reg;
    logic [KEY_W-1:0]  clr_cnt_next;
    logic [KEY_W-1:0]  last_hit_reg;
    logic [KEY_W-1:0]  last_hit_next;
    res_kind_t         kind_reg;
    res_kind_t         kind_next;
    logic [7:0]        imm_reg;
    logic [7:0]        imm_next;
    logic [7:0]        result_reg;
    logic [7:0]        result_next;
    logic              done_reg;

    logic              accept;
    logic [7:0]        rev_entry;
    ksq_ring_cmd_t     ring_cmd;
    ksq_ring_stat_t    ring_stat;
    logic [KEY_W-1:0]  ring_key;
    logic              map_we;
    logic [KEY_W-1:0]  map_waddr;
    logic              map_wdata;
    logic [KEY_W-1:0]  map_raddr;
    logic              map_rdata;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign rev_entry = REV_ROM[data_byte];

    // ring commands
    assign ring_cmd.push  = accept && (operation == OP_SCAN) && !data_byte[7];
    assign ring_cmd.pop   = accept && (operation == OP_POP);
    assign ring_cmd.flush = accept && (operation == OP_FLUSH);
    assign ring_cmd.key   = data_byte[KEY_W-1:0];

    ksq_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (ring_cmd),
        .stat   (ring_stat),
        .rd_key (ring_key)
    );

    // pressed map port muxing: clearing pass or scan byte write
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            map_we    = 1'b1;
            map_waddr = clr_cnt_reg;
            map_wdata = 1'b0;
        end
        else
        begin
            map_we    = accept && (operation == OP_SCAN);
            map_waddr = data_byte[KEY_W-1:0];
            map_wdata = !data_byte[7];
        end
        map_raddr = (operation == OP_PASCII) ? rev_entry[KEY_W-1:0]
                                             : data_byte[KEY_W-1:0];
    end

    ksq_ram #(
        .WIDTH (1),
        .DEPTH (KEY_COUNT)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    // request decode: result source and last hit update
    always_comb
    begin
        kind_next     = kind_reg;
        imm_next      = imm_reg;
        last_hit_next = last_hit_reg;
        if (accept)
        begin
            kind_next = RES_ZERO;
            case (operation)
                OP_SCAN:
                begin
                    if (!data_byte[7])
                    begin
                        last_hit_next = data_byte[KEY_W-1:0];
                    end
                end
                OP_POP:
                begin
                    kind_next = ring_stat.empty ? RES_ZERO : RES_ASCII;
                end
                OP_LAST:
                begin
                    kind_next     = RES_IMM;
                    imm_next      = {1'b0, last_hit_reg};
                    last_hit_next = '0;
                end
                OP_PSCAN:
                begin
                    kind_next = RES_BIT;
                end
                OP_PASCII:
                begin
                    kind_next = rev_entry[7] ? RES_BIT : RES_ZERO;
                end
                OP_FLUSH:
                begin
                    last_hit_next = '0;
                end
                default:
                begin
                    kind_next = RES_ZERO;
                end
            endcase
        end
    end

    // result assembly once the memories have answered
    always_comb
    begin
        case (kind_reg)
            RES_ZERO:  result_next = 8'h00;
            RES_IMM:   result_next = imm_reg;
            RES_ASCII: result_next = ASCII_ROM[{1'b0, ring_key}];
            RES_BIT:   result_next = {7'b0, map_rdata};
            default:   result_next = 8'h00;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == KEY_W'(KEY_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            last_hit_reg <= '0;
            kind_reg     <= RES_ZERO;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            last_hit_reg <= last_hit_next;
            kind_reg     <= kind_next;
            done_reg     <= (state_reg == ST_EXEC);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        imm_reg <= imm_next;
        if (state_reg == ST_EXEC)
        begin
            result_reg <= result_next;
        end
    end

    assign done       = done_reg;
    assign read_value = result_reg;

    // every accepted request is answered with done after the execute state
    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("request not answered two cycles after acceptance");

    // a result only follows the memory read cycle
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_EXEC))
        else $error("result strobe without a request in flight");

    // ring cannot be empty and full together
    a_ring_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(ring_stat.empty && ring_stat.full))
        else $error("ring reports empty and full together");

    // no request is taken during the clearing pass
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |=> !$past(accept))
        else $error("request accepted while clearing the pressed map");

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyboard scan queue. A directed table covers
// the reset state, extreme codes, spare operations, the reverse ascii lookup
// and flush. A random mix of typing, queries, pops and a ring fill follows.
// Every read value is checked against a fixed row's typed value or a local
// model of the key map, the press ring and the last hit latch.
// ----------------------------------------------------------------------------
module tb_top;
    import ksq_pkg::*;

    // spare operation codes, no effect on state
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam int RING_SLOTS   = 128;
    localparam int SEARCH_SPAN  = 255;
    localparam int RANDOM_ITEMS = 300;
    localparam int STALL_LIMIT  = 2000;

    // scan code to ascii, unshifted half then shifted half
    localparam logic [7:0] KEY_ASCII [256] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h8B, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h89, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h8A, 8'h00,
        8'h8C, 8'h20, 8'h00, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91,
        8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h00, 8'h00, 8'h84,
        8'h82, 8'h85, 8'h00, 8'h80, 8'h00, 8'h81, 8'h00, 8'h86,
        8'h83, 8'h87, 8'h88, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h97,
        8'h98, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h8B, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h89, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h8A, 8'h00,
        8'h8C, 8'h20, 8'h00, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91,
        8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h00, 8'h00, 8'h84,
        8'h82, 8'h85, 8'h00, 8'h80, 8'h00, 8'h81, 8'h00, 8'h86,
        8'h83, 8'h87, 8'h88, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h97,
        8'h98, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // one directed request; fixed rows carry the read value typed in
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic       fixed;
        logic [7:0] value;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 26;

    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{OP_POP,      8'h00, 1'b1, 8'h00},   // empty ring after reset
        '{OP_LAST,     8'hFF, 1'b1, 8'h00},
        '{OP_PSCAN,    8'h7F, 1'b1, 8'h00},
        '{OP_PASCII,   8'h61, 1'b1, 8'h00},
        '{OP_SPARE_LO, 8'hFF, 1'b1, 8'h00},
        '{OP_SPARE_HI, 8'h55, 1'b1, 8'h00},
        '{OP_SCAN,     8'h00, 1'b1, 8'h00},   // lowest key
        '{OP_SCAN,     8'h7F, 1'b1, 8'h00},   // highest key
        '{OP_SCAN,     8'h1E, 1'b1, 8'h00},
        '{OP_SCAN,     8'h1E, 1'b1, 8'h00},   // repeated press
        '{OP_PSCAN,    8'h9E, 1'b0, 8'h00},   // top bit of scan code ignored
        '{OP_PASCII,   8'h41, 1'b0, 8'h00},   // match in the shifted half
        '{OP_PASCII,   8'hFF, 1'b1, 8'h00},   // no match anywhere
        '{OP_PASCII,   8'h1B, 1'b0, 8'h00},
        '{OP_LAST,     8'h00, 1'b0, 8'h00},
        '{OP_LAST,     8'h00, 1'b0, 8'h00},   // cleared by the read before
        '{OP_POP,      8'h00, 1'b0, 8'h00},
        '{OP_POP,      8'h00, 1'b0, 8'h00},
        '{OP_POP,      8'h00, 1'b0, 8'h00},
        '{OP_POP,      8'h00, 1'b0, 8'h00},
        '{OP_POP,      8'h00, 1'b1, 8'h00},   // drained
        '{OP_SCAN,     8'h9E, 1'b1, 8'h00},   // release
        '{OP_PSCAN,    8'h1E, 1'b0, 8'h00},
        '{OP_SCAN,     8'h80, 1'b1, 8'h00},
        '{OP_FLUSH,    8'hFF, 1'b1, 8'h00},
        '{OP_PSCAN,    8'h7F, 1'b0, 8'h00}    // pressed bits survive flush
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic [2:0] operation = OP_SCAN;
    logic [7:0] data_byte = 8'h00;
    logic       busy;
    logic       done;
    logic [7:0] read_value;

    // typed expectation travelling with the request
    logic       row_fixed = 1'b0;
    logic [7:0] row_value = 8'h00;

    // local copy of the keyboard state
    bit         key_down [128];
    logic [6:0] ring_keys [RING_SLOTS];
    int         ring_head = 0;
    int         ring_tail = 0;
    logic [6:0] last_key = 7'd0;

    logic [7:0] pending_reads [$];
    logic [7:0] want_value;
    logic [7:0] model_value;

    int err_count = 0;
    int req_count = 0;
    int read_count = 0;
    int idle_cycles = 0;
    int dropped_presses = 0;
    int empty_pops = 0;
    int unmatched_ascii = 0;
    bit quiet_stretch = 1'b0;

    keyboard_scan_queue_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .data_byte  (data_byte),
        .done       (done),
        .read_value (read_value)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // reverse lookup: first matching table entry, folded onto the key range
    function automatic logic [7:0] ascii_key_down(input logic [7:0] code);
        for (int i = 0; i < SEARCH_SPAN; i++)
        begin
            if (KEY_ASCII[i] == code)
                return {7'd0, key_down[i % 128]};
        end
        unmatched_ascii++;
        return 8'h00;
    endfunction

    // advance the local keyboard state by one request and return its read value
    function automatic logic [7:0] keyboard_read(input logic [2:0] op,
                                                 input logic [7:0] data);
        logic [7:0] value;
        logic [6:0] key;
        int         next_tail;
        value = 8'h00;
        key = data[6:0];
        case (op)
            OP_SCAN:
            begin
                key_down[key] = !data[7];
                if (!data[7])
                begin
                    last_key = key;
                    next_tail = (ring_tail + 1) % RING_SLOTS;
                    if (next_tail != ring_head)
                    begin
                        ring_keys[ring_tail] = key;
                        ring_tail = next_tail;
                    end
                    else
                        dropped_presses++;
                end
            end
            OP_POP:
            begin
                if (ring_head != ring_tail)
                begin
                    value = KEY_ASCII[{1'b0, ring_keys[ring_head]}];
                    ring_head = (ring_head + 1) % RING_SLOTS;
                end
                else
                    empty_pops++;
            end
            OP_LAST:
            begin
                value = {1'b0, last_key};
                last_key = 7'd0;
            end
            OP_PSCAN:
                value = {7'd0, key_down[key]};
            OP_PASCII:
                value = ascii_key_down(data);
            OP_FLUSH:
            begin
                ring_head = 0;
                ring_tail = 0;
                last_key = 7'd0;
            end
            default:
                value = 8'h00;
        endcase
        return value;
    endfunction

    // result check, request capture and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                read_count++;
                if (pending_reads.size() == 0)
                begin
                    $error("read_value: no request outstanding, got %0d", read_value);
                    err_count++;
                end
                else
                begin
                    want_value = pending_reads.pop_front();
                    if (read_value !== want_value)
                    begin
                        $error("read_value: expected %0d, got %0d", want_value, read_value);
                        err_count++;
                    end
                end
            end
            if (start && busy === 1'b0)
            begin
                req_count++;
                model_value = keyboard_read(operation, data_byte);
                pending_reads.push_back(row_fixed ? row_value : model_value);
            end
            if (done === 1'b1 || (start && busy === 1'b0))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no request or result for %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // hold one request until taken, sometimes with a random gap in front of it
    task automatic send_request(input logic [2:0] op, input logic [7:0] data,
                                input logic fixed, input logic [7:0] value);
        int gap;
        gap = 0;
        if (!quiet_stretch && $urandom_range(99) < 33)
            gap = $urandom_range(4, 1);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        operation <= op;
        data_byte <= data;
        row_fixed <= fixed;
        row_value <= value;
        do
            @(negedge clk);
        while (busy !== 1'b0);
        @(posedge clk);
    endtask

    // stop sending until every outstanding read has come back
    task automatic drain_reads();
        start <= 1'b0;
        @(posedge clk);
        while (pending_reads.size() != 0)
            @(posedge clk);
    endtask

    // key choice biased towards the populated part of the table
    function automatic logic [6:0] pick_key();
        if ($urandom_range(3) != 0)
            return 7'($urandom_range(8'h58));
        return 7'($urandom_range(127));
    endfunction

    task automatic random_request();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            if ($urandom_range(9) < 7)
                send_request(OP_SCAN, {1'b0, pick_key()}, 1'b0, 8'h00);
            else
                send_request(OP_SCAN, {1'b1, pick_key()}, 1'b0, 8'h00);
        end
        else if (pick < 55)
            send_request(OP_POP, 8'($urandom_range(255)), 1'b0, 8'h00);
        else if (pick < 63)
            send_request(OP_LAST, 8'($urandom_range(255)), 1'b0, 8'h00);
        else if (pick < 75)
            send_request(OP_PSCAN, 8'($urandom_range(255)), 1'b0, 8'h00);
        else if (pick < 92)
        begin
            if ($urandom_range(9) < 7)
                send_request(OP_PASCII, KEY_ASCII[$urandom_range(255)], 1'b0, 8'h00);
            else
                send_request(OP_PASCII, 8'($urandom_range(255)), 1'b0, 8'h00);
        end
        else if (pick < 94)
            send_request(OP_FLUSH, 8'($urandom_range(255)), 1'b0, 8'h00);
        else if (pick < 97)
            send_request(OP_SPARE_LO, 8'($urandom_range(255)), 1'b0, 8'h00);
        else
            send_request(OP_SPARE_HI, 8'($urandom_range(255)), 1'b0, 8'h00);
    endtask

    // main sequence
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_request(DIRECTED[i].op, DIRECTED[i].data,
                         DIRECTED[i].fixed, DIRECTED[i].value);
        drain_reads();

        // random mix with a ring fill, a drain pause and a stretch without gaps
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            quiet_stretch = (i >= 200 && i < 280);
            if (i == 150)
            begin
                // fill past capacity, then pop 60 keys back out so the pointers wrap
                for (int k = 0; k < RING_SLOTS + 8; k++)
                    send_request(OP_SCAN, {1'b0, pick_key()}, 1'b0, 8'h00);
                for (int k = 0; k < 60; k++)
                    send_request(OP_POP, 8'($urandom_range(255)), 1'b0, 8'h00);
            end
            if (i == 280)
                drain_reads();
            random_request();
        end
        quiet_stretch = 1'b0;

        // wait for the tail of the results, then idle on for strays
        drain_reads();
        repeat (8) @(posedge clk);

        $display("covered %0d requests and %0d reads, %0d presses dropped on a full ring",
                 req_count, read_count, dropped_presses);
        $display("%0d pops on an empty ring, %0d ascii queries without a match",
                 empty_pops, unmatched_ascii);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/ksq_pkg.sv
hw/rtl/ksq_ram.sv
hw/rtl/ksq_ring.sv
hw/rtl/keyboard_scan_queue_core.sv
dv/tb_top.sv
